// ----- hw/rtl/lss_pkg.sv -----
`default_nettype none

package lss_pkg;

	// Grid and number format.
	localparam int MAX_GRID   = 1024;
	localparam int VALUE_W    = 32;
	localparam int ADDR_W     = $clog2(MAX_GRID);
	localparam int COORD_W    = 10;
	localparam int PEAK_W     = VALUE_W - 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COORD_W;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic [PEAK_W-1:0]         peak_t;
	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

	// Register indexes on the configuration port.
	localparam cfg_idx_t REG_GRID_SIZE = CFG_IDX_W'(0);
	localparam cfg_idx_t REG_METHOD    = CFG_IDX_W'(1);

	// Relaxation methods.
	localparam logic METHOD_JACOBI       = 1'b0;
	localparam logic METHOD_GAUSS_SEIDEL = 1'b1;

	localparam coord_t GRID_SIZE_RESET = COORD_W'(8);

	// Per-item decisions taken when the word is accepted.
	typedef struct packed {
		logic interior;
		logic emit_upper;
		logic emit_last_row;
		logic last_col;
		logic sweep_end;
		logic gauss_seidel;
	} item_flags_t;

	// One result word without the residual peak.
	typedef struct packed {
		value_t value;
		coord_t row;
		coord_t column;
		logic   done;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lss_in_if.sv -----
`default_nettype none

interface lss_in_if;
	import lss_pkg::*;

	logic   valid;
	logic   ready;
	value_t cell_value;
	value_t source_term;

	modport source (output valid, output cell_value, output source_term, input ready);
	modport sink (input valid, input cell_value, input source_term, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lss_out_if.sv -----
`default_nettype none

interface lss_out_if;
	import lss_pkg::*;

	logic   valid;
	logic   ready;
	value_t new_value;
	coord_t row;
	coord_t column;
	peak_t  max_residual;
	logic   sweep_done;
	logic   run_last;

	modport source (output valid, output new_value, output row, output column,
		output max_residual, output sweep_done, output run_last, input ready);
	modport sink (input valid, input new_value, input row, input column,
		input max_residual, input sweep_done, input run_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lss_cfg_if.sv -----
`default_nettype none

interface lss_cfg_if;
	import lss_pkg::*;

	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lss_ram.sv -----
`default_nettype none

module lss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Read-first: a read and a write of one address in a cycle return the old data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end
endmodule

`default_nettype wire

// ----- hw/rtl/lss_stencil.sv -----
`default_nettype none

module lss_stencil (
	input  wire lss_pkg::value_t up,
	input  wire lss_pkg::value_t left,
	input  wire lss_pkg::value_t right,
	input  wire lss_pkg::value_t down,
	input  wire lss_pkg::value_t source,
	input  wire lss_pkg::value_t old,
	output      lss_pkg::value_t new_value,
	output      lss_pkg::peak_t  residual
);
	import lss_pkg::*;

	logic [VALUE_W+1:0] sum4;
	logic [VALUE_W-1:0] quarter;
	logic [VALUE_W:0]   with_src;
	logic [VALUE_W:0]   diff;
	logic [VALUE_W:0]   mag;

	// Quarter of the neighbor sum, rounded toward minus infinity.
	always_comb begin
		sum4 = {{2{up[VALUE_W-1]}}, up} + {{2{left[VALUE_W-1]}}, left}
			+ {{2{right[VALUE_W-1]}}, right} + {{2{down[VALUE_W-1]}}, down};
		quarter = sum4[VALUE_W+1:2];
	end

	// Add the source term and saturate to the value range.
	always_comb begin
		with_src = {quarter[VALUE_W-1], quarter} + {source[VALUE_W-1], source};
		if (with_src[VALUE_W] != with_src[VALUE_W-1]) begin
			new_value = with_src[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
				: {1'b0, {(VALUE_W-1){1'b1}}};
		end else begin
			new_value = with_src[VALUE_W-1:0];
		end
	end

	// Absolute change of the cell, saturated to the peak field.
	always_comb begin
		diff = {old[VALUE_W-1], old} - {new_value[VALUE_W-1], new_value};
		mag  = diff[VALUE_W] ? (~diff + (VALUE_W+1)'(1)) : diff;
		if (|mag[VALUE_W:PEAK_W]) begin
			residual = '1;
		end else begin
			residual = mag[PEAK_W-1:0];
		end
	end
endmodule

`default_nettype wire

// ----- hw/rtl/lss_out_buf.sv -----
`default_nettype none

module lss_out_buf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic             a_en,
	input  wire logic             b_en,
	input  wire lss_pkg::result_t rec_a,
	input  wire lss_pkg::result_t rec_b,
	input  wire lss_pkg::peak_t   peak,
	output      logic             can_load,
	lss_out_if.source             results
);
	import lss_pkg::*;

	logic    a_pend_q;
	logic    b_pend_q;
	result_t rec_a_q;
	result_t rec_b_q;
	peak_t   peak_q;
	result_t shown;
	logic    take;

	// The upper-row word goes out before the last-row word of the same item.
	always_comb begin
		shown                = a_pend_q ? rec_a_q : rec_b_q;
		results.valid        = a_pend_q || b_pend_q;
		results.new_value    = shown.value;
		results.row          = shown.row;
		results.column       = shown.column;
		results.sweep_done   = shown.done;
		results.max_residual = peak_q;
		results.run_last     = !(a_pend_q && b_pend_q);
		take                 = results.valid && results.ready;
		can_load             = !results.valid || (take && results.run_last);
	end

	// Pending flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_pend_q <= 1'b0;
			b_pend_q <= 1'b0;
		end else if (load) begin
			a_pend_q <= a_en;
			b_pend_q <= b_en;
		end else if (take) begin
			if (a_pend_q) begin
				a_pend_q <= 1'b0;
			end else begin
				b_pend_q <= 1'b0;
			end
		end
	end

	// Result words.
	always_ff @(posedge clk) begin
		if (load) begin
			rec_a_q <= rec_a;
			rec_b_q <= rec_b;
			peak_q  <= peak;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("result buffer loaded while a word is still pending");

	a_second_word: assert property (@(posedge clk) disable iff (!arst_n)
		take && !results.run_last |=> results.valid && results.run_last)
		else $error("second word of an item missing after the first");
endmodule

`default_nettype wire

// ----- hw/rtl/laplace_stencil_sweep_unit.sv -----
`default_nettype none

// Channel   Dir  Payload                                                   Accepted when
// samples   in   cell_value, source_term                                   valid && ready
// results   out  new_value, row, column, max_residual, sweep_done, run_last valid && ready
// cfg       in   index, data                                               valid && ready
//
// One input word per cycle while the output keeps up; a word of the last grid row yields two
// result words (one if it is also the first row), which share the single output port, so
// the input waits while the first of them goes out. A result word passes the input register
// with the row memory reads, then the stencil adder tree into the output buffer register.
// Reset clears counters and the residual peak and loads the default configuration; the row
// memories are not cleared and hold valid data once the first row of a sweep has passed.
// A stalled output holds the input register; the cfg port is always ready.
module laplace_stencil_sweep_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	lss_in_if.sink    samples,
	lss_out_if.source results,
	lss_cfg_if.sink   cfg
);
	import lss_pkg::*;

	coord_t      grid_q;
	logic        method_q;
	coord_t      row_q;
	coord_t      col_q;
	peak_t       peak_q;
	value_t      left_q;

	logic        s1_valid_q;
	value_t      x_s1;
	coord_t      row_s1;
	coord_t      col_s1;
	item_flags_t flags_s1;
	logic        up_byp_s1;
	value_t      up_byp_data_s1;

	logic        in_acc;
	logic        s1_adv;
	logic        obuf_load;
	logic        obuf_can_load;
	item_flags_t flags_in;
	coord_t      row_m1;
	addr_t       col_addr;
	addr_t       right_addr;
	addr_t       col_s1_addr;

	value_t      old_rd;
	value_t      right_rd;
	value_t      src_rd;
	value_t      upper_rd;
	value_t      up_val;
	value_t      kernel_val;
	peak_t       kernel_res;
	value_t      cell_val;
	value_t      upper_wd;
	logic        upper_we;
	peak_t       new_peak;
	result_t     rec_a;
	result_t     rec_b;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q   <= GRID_SIZE_RESET;
			method_q <= METHOD_JACOBI;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GRID_SIZE: grid_q   <= cfg.data;
				REG_METHOD:    method_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Input handshake and per-item decisions.
	assign samples.ready = !s1_valid_q || s1_adv;
	assign in_acc        = samples.valid && samples.ready;
	assign row_m1        = row_q - COORD_W'(1);
	assign col_addr      = col_q[ADDR_W-1:0];
	assign right_addr    = col_addr + ADDR_W'(1);
	assign col_s1_addr   = col_s1[ADDR_W-1:0];

	always_comb begin
		flags_in.emit_upper    = (row_q != '0);
		flags_in.emit_last_row = (row_q >= grid_q);
		flags_in.last_col      = (col_q >= grid_q);
		flags_in.sweep_end     = (col_q >= grid_q) && (row_q >= grid_q);
		flags_in.interior      = (row_q >= COORD_W'(2)) && (row_m1 < grid_q)
			&& (col_q != '0) && (col_q < grid_q);
		flags_in.gauss_seidel  = (method_q == METHOD_GAUSS_SEIDEL);
	end

	// Raster position of the next input word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (col_q >= grid_q) begin
				col_q <= '0;
				if (row_q >= grid_q) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + COORD_W'(1);
				end
			end else begin
				col_q <= col_q + COORD_W'(1);
			end
		end
	end

	// Row memories: old values (two read copies), source terms and the upper row.
	lss_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_GRID)) u_prev_a (
		.clk(clk), .we(in_acc), .waddr(col_addr), .wdata(samples.cell_value),
		.re(in_acc), .raddr(col_addr), .rdata(old_rd)
	);

	lss_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_GRID)) u_prev_b (
		.clk(clk), .we(in_acc), .waddr(col_addr), .wdata(samples.cell_value),
		.re(in_acc), .raddr(right_addr), .rdata(right_rd)
	);

	lss_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_GRID)) u_source (
		.clk(clk), .we(in_acc), .waddr(col_addr), .wdata(samples.source_term),
		.re(in_acc), .raddr(col_addr), .rdata(src_rd)
	);

	lss_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_GRID)) u_upper (
		.clk(clk), .we(upper_we), .waddr(col_s1_addr), .wdata(upper_wd),
		.re(in_acc), .raddr(col_addr), .rdata(upper_rd)
	);

	// Input register; an upper-row write in the same cycle to the same column is bypassed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (samples.ready) begin
			s1_valid_q <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1           <= samples.cell_value;
			row_s1         <= row_q;
			col_s1         <= col_q;
			flags_s1       <= flags_in;
			up_byp_s1      <= upper_we && (col_s1_addr == col_addr);
			up_byp_data_s1 <= upper_wd;
		end
	end

	// Stencil update of the cell one row above the input.
	assign up_val = up_byp_s1 ? up_byp_data_s1 : upper_rd;

	lss_stencil u_stencil (
		.up(up_val), .left(left_q), .right(right_rd), .down(x_s1),
		.source(src_rd), .old(old_rd), .new_value(kernel_val), .residual(kernel_res)
	);

	always_comb begin
		cell_val = flags_s1.interior ? kernel_val : old_rd;
		upper_wd = flags_s1.gauss_seidel ? cell_val : old_rd;
		new_peak = (flags_s1.interior && (kernel_res > peak_q)) ? kernel_res : peak_q;
	end

	// Advance to the result buffer; first-row items leave no word unless it is the last row.
	assign s1_adv    = s1_valid_q
		&& (!(flags_s1.emit_upper || flags_s1.emit_last_row) || obuf_can_load);
	assign obuf_load = s1_adv && (flags_s1.emit_upper || flags_s1.emit_last_row);
	assign upper_we  = s1_adv && flags_s1.emit_upper;

	// Left neighbor and running residual peak.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			peak_q <= '0;
		end else if (s1_adv) begin
			if (flags_s1.emit_upper) begin
				left_q <= upper_wd;
			end
			peak_q <= flags_s1.sweep_end ? '0 : new_peak;
		end
	end

	// Result words.
	always_comb begin
		rec_a.value  = cell_val;
		rec_a.row    = row_s1 - COORD_W'(1);
		rec_a.column = col_s1;
		rec_a.done   = 1'b0;
		rec_b.value  = x_s1;
		rec_b.row    = row_s1;
		rec_b.column = col_s1;
		rec_b.done   = flags_s1.last_col;
	end

	lss_out_buf u_out_buf (
		.clk(clk), .arst_n(arst_n), .load(obuf_load),
		.a_en(flags_s1.emit_upper), .b_en(flags_s1.emit_last_row),
		.rec_a(rec_a), .rec_b(rec_b), .peak(new_peak),
		.can_load(obuf_can_load), .results(results)
	);

	a_peak_rises: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && !flags_s1.sweep_end |=> peak_q >= $past(peak_q))
		else $error("residual peak fell inside a sweep");

	a_sweep_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (col_q >= grid_q) && (row_q >= grid_q) |=> row_q == '0 && col_q == '0)
		else $error("raster position not cleared at the end of a sweep");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.sweep_done |-> results.run_last)
		else $error("sweep end flagged on a word that is not the last of its item");
endmodule

`default_nettype wire

// ----- verif/laplace_stencil_sweep_unit_tb.sv -----
`default_nettype none

module laplace_stencil_sweep_unit_tb;
	import lss_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 6;
	// Margin for the pipeline to drain before a register write.
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 4000;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_CELLS  = 420;

	localparam longint VALUE_CEIL  = 64'sd2147483647;
	localparam longint VALUE_FLOOR = -64'sd2147483648;
	localparam longint PEAK_CEIL   = 64'sd2147483647;
	localparam value_t CELL_MAX    = 32'sh7fffffff;
	localparam value_t CELL_MIN    = 32'sh80000000;

	typedef enum int {FLAVOR_WIDE, FLAVOR_SMOOTH, FLAVOR_EXTREME} flavor_t;

	typedef struct {
		value_t new_value;
		coord_t row;
		coord_t column;
		peak_t  max_residual;
		logic   sweep_done;
		logic   run_last;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n;

	lss_in_if  samples_ch ();
	lss_out_if results_ch ();
	lss_cfg_if cfg_ch ();

	laplace_stencil_sweep_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Mirror of the sweep state: old and source rows, the row above, counters, peak.
	value_t old_row [MAX_GRID];
	value_t source_mem [MAX_GRID];
	value_t above_row [MAX_GRID];
	value_t left_value;
	coord_t row_pos;
	coord_t col_pos;
	peak_t  residual_max;
	coord_t grid_n;
	logic   sweep_method;

	result_word_t expected_results [$];
	int      mismatches     = 0;
	int      cells_accepted = 0;
	int      burst_left     = 0;
	bit      gapless        = 1'b0;
	int      hold_request   = 0;
	flavor_t cell_flavor    = FLAVOR_WIDE;

	function automatic value_t clamp_value(longint x);
		if (x > VALUE_CEIL) begin
			return CELL_MAX;
		end
		if (x < VALUE_FLOOR) begin
			return CELL_MIN;
		end
		return value_t'(x);
	endfunction

	// Relax one accepted cell and queue the result words that it causes.
	task automatic relax_cell(value_t cell_word, value_t source);
		coord_t       r;
		coord_t       c;
		value_t       old_v;
		value_t       new_v;
		longint       total;
		longint       residual;
		result_word_t upper_w;
		result_word_t last_w;
		logic         has_upper;
		r = row_pos;
		c = col_pos;
		has_upper = 1'b0;
		if (r >= 1) begin
			old_v = old_row[c];
			new_v = old_v;
			if (r - 1 >= 1 && r - 1 < grid_n && c >= 1 && c < grid_n) begin
				total = longint'(above_row[c]) + longint'(left_value) +
					longint'(old_row[coord_t'(c + 1)]) + longint'(cell_word);
				new_v = clamp_value((total >>> 2) + longint'(source_mem[c]));
				residual = longint'(old_v) - longint'(new_v);
				if (residual < 0) begin
					residual = -residual;
				end
				if (residual > PEAK_CEIL) begin
					residual = PEAK_CEIL;
				end
				if (residual > longint'(residual_max)) begin
					residual_max = peak_t'(residual);
				end
			end
			above_row[c] = (sweep_method == METHOD_GAUSS_SEIDEL) ? new_v : old_v;
			left_value = above_row[c];
			upper_w.new_value = new_v;
			upper_w.row = r - coord_t'(1);
			upper_w.column = c;
			upper_w.max_residual = residual_max;
			upper_w.sweep_done = 1'b0;
			upper_w.run_last = 1'b1;
			has_upper = 1'b1;
		end
		old_row[c] = cell_word;
		source_mem[c] = source;
		// A last-row cell comes out right away as the second word.
		if (r >= grid_n) begin
			upper_w.run_last = 1'b0;
			last_w.new_value = cell_word;
			last_w.row = r;
			last_w.column = c;
			last_w.max_residual = residual_max;
			last_w.sweep_done = (c >= grid_n);
			last_w.run_last = 1'b1;
		end
		if (has_upper) begin
			expected_results.push_back(upper_w);
		end
		if (r >= grid_n) begin
			expected_results.push_back(last_w);
		end
		if (c >= grid_n) begin
			col_pos = '0;
			if (r >= grid_n) begin
				row_pos = '0;
				residual_max = '0;
			end else begin
				row_pos = r + coord_t'(1);
			end
		end else begin
			col_pos = c + coord_t'(1);
		end
	endtask

	function automatic value_t pick_value(flavor_t flavor);
		case (flavor)
			FLAVOR_WIDE: begin
				return value_t'($urandom);
			end
			FLAVOR_SMOOTH: begin
				return value_t'(int'($urandom_range(0, 65535)) - 32768);
			end
			default: begin
				case ($urandom_range(0, 5))
					0: return CELL_MAX;
					1: return CELL_MIN;
					2: return '0;
					3: return '1;
					4: return value_t'(1);
					default: return value_t'($urandom);
				endcase
			end
		endcase
	endfunction

	function automatic value_t pick_source(flavor_t flavor);
		if ($urandom_range(0, 2) == 0) begin
			return '0;
		end
		return pick_value(flavor);
	endfunction

	// Offer one cell word; valid stays high for the next call.
	task automatic push_cell(value_t cell_word, value_t source);
		int gap;
		if (!gapless && burst_left == 0) begin
			gap = $urandom_range(1, 10);
			burst_left = $urandom_range(1, 48);
			samples_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end else if (burst_left > 0) begin
			burst_left--;
		end
		samples_ch.valid <= 1'b1;
		samples_ch.cell_value <= cell_word;
		samples_ch.source_term <= source;
		do @(posedge clk); while (!samples_ch.ready);
		cells_accepted++;
		relax_cell(cell_word, source);
	endtask

	task automatic park_samples();
		samples_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_cells(int count);
		repeat (count) push_cell(pick_value(cell_flavor), pick_source(cell_flavor));
		park_samples();
	endtask

	// Keep sending until the counters wrap back to the start of a sweep.
	task automatic finish_sweep();
		do begin
			push_cell(pick_value(cell_flavor), pick_source(cell_flavor));
		end while (row_pos != 0 || col_pos != 0);
		park_samples();
	endtask

	task automatic wait_results();
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(cfg_idx_t idx, cfg_data_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_GRID_SIZE) begin
			grid_n = coord_t'(value);
		end else begin
			sweep_method = value[0];
		end
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(cfg_data_t n, logic method);
		settle();
		if ($urandom_range(0, 1) == 1) begin
			set_register(REG_GRID_SIZE, n);
			set_register(REG_METHOD, cfg_data_t'(method));
		end else begin
			set_register(REG_METHOD, cfg_data_t'(method));
			set_register(REG_GRID_SIZE, n);
		end
	endtask

	task automatic push_grid3(value_t rim, value_t center, value_t source);
		for (int k = 0; k < 9; k++) begin
			push_cell((k == 4) ? center : rim, source);
		end
		park_samples();
	endtask

	// One sweep on the configuration that reset leaves.
	task automatic test_reset_defaults();
		cell_flavor = FLAVOR_SMOOTH;
		finish_sweep();
	endtask

	// Single-cell sweeps, an all-border grid, and saturation of value and residual.
	task automatic test_corner_values();
		configure(cfg_data_t'(0), METHOD_JACOBI);
		push_cell(CELL_MAX, CELL_MIN);
		push_cell(CELL_MIN, CELL_MAX);
		push_cell('0, '1);
		push_cell('1, '0);
		park_samples();
		configure(cfg_data_t'(1), METHOD_GAUSS_SEIDEL);
		push_cell(CELL_MAX, CELL_MAX);
		push_cell(CELL_MIN, CELL_MAX);
		push_cell(CELL_MIN, CELL_MAX);
		push_cell(CELL_MAX, CELL_MAX);
		park_samples();
		configure(cfg_data_t'(2), METHOD_GAUSS_SEIDEL);
		push_grid3(CELL_MAX, CELL_MIN, CELL_MAX);
		configure(cfg_data_t'(2), METHOD_JACOBI);
		push_grid3(CELL_MIN, CELL_MAX, CELL_MIN);
	endtask

	// One full row at the largest size and the start of the next, then the grid
	// shrinks so that the row counter sits at the new last row and the column
	// counter beyond it.
	task automatic test_full_width_rows();
		cell_flavor = FLAVOR_WIDE;
		configure(cfg_data_t'(1023), METHOD_JACOBI);
		send_cells(MAX_GRID + 16);
		settle();
		set_register(REG_GRID_SIZE, cfg_data_t'(1));
		finish_sweep();
	endtask

	// The grid shrinks in the middle of a row, leaving the column counter beyond it.
	task automatic test_shrink_mid_row();
		cell_flavor = FLAVOR_EXTREME;
		configure(cfg_data_t'(16), METHOD_GAUSS_SEIDEL);
		send_cells(17 + 10);
		settle();
		set_register(REG_GRID_SIZE, cfg_data_t'(4));
		finish_sweep();
	endtask

	// The receiver holds off for a long stretch while cells keep coming.
	task automatic test_output_backpressure();
		cell_flavor = FLAVOR_WIDE;
		configure(cfg_data_t'(6), METHOD_GAUSS_SEIDEL);
		gapless = 1'b1;
		hold_request = LONG_HOLD;
		finish_sweep();
		gapless = 1'b0;
	endtask

	// The sender stops mid-sweep until every queued result has come out.
	task automatic test_sender_pause();
		cell_flavor = FLAVOR_SMOOTH;
		configure(cfg_data_t'(5), METHOD_JACOBI);
		send_cells(20);
		wait_results();
		finish_sweep();
	endtask

	// Mostly small sweeps with random method and content; a few change the grid
	// size part way through. Every row entry that such a change can reach has
	// been written by now.
	task automatic test_random_sweeps();
		int     start;
		int     pick;
		coord_t n;
		start = cells_accepted;
		while (cells_accepted - start < RANDOM_CELLS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				n = '0;
			end else if (pick == 1) begin
				n = coord_t'(1);
			end else if (pick < 16) begin
				n = coord_t'($urandom_range(2, 7));
			end else begin
				n = coord_t'($urandom_range(8, 24));
			end
			cell_flavor = flavor_t'($urandom_range(0, 2));
			gapless = ($urandom_range(0, 5) == 0);
			configure(cfg_data_t'(n), logic'($urandom_range(0, 1)));
			if (n >= 2 && $urandom_range(0, 7) == 0) begin
				send_cells($urandom_range(1, (int'(n) + 1) * (int'(n) + 1) - 1));
				settle();
				set_register(REG_GRID_SIZE, cfg_data_t'($urandom_range(0, 12)));
			end
			finish_sweep();
		end
		gapless = 1'b0;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$error("%s: expected %0h, actual %0h", name, want, got);
		end
	endtask

	// Compare every accepted result word with the oldest expectation.
	always @(posedge clk) begin
		result_word_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$error("unexpected result word: row %0d column %0d", results_ch.row,
					results_ch.column);
			end else begin
				want = expected_results.pop_front();
				check_field("new_value", want.new_value, results_ch.new_value);
				check_field("row", 32'(want.row), 32'(results_ch.row));
				check_field("column", 32'(want.column), 32'(results_ch.column));
				check_field("max_residual", 32'(want.max_residual),
					32'(results_ch.max_residual));
				check_field("sweep_done", 32'(want.sweep_done), 32'(results_ch.sweep_done));
				check_field("run_last", 32'(want.run_last), 32'(results_ch.run_last));
			end
		end
	end

	// Receiver: a long hold on request, otherwise a stall pattern that changes now and then.
	initial begin
		int hold_left;
		int mode;
		int mode_left;
		int keep_pct;
		int period;
		int tick;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		keep_pct = 50;
		period = 3;
		tick = 0;
		results_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(64, 256);
				keep_pct = $urandom_range(30, 90);
				period = $urandom_range(2, 7);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else if (mode == 0) begin
				results_ch.ready <= 1'b1;
			end else if (mode == 1) begin
				results_ch.ready <= ($urandom_range(0, 99) < keep_pct);
			end else begin
				results_ch.ready <= (tick % period != 0);
			end
		end
	end

	// Watchdog on cycles in which no channel moves a word.
	always @(posedge clk) begin
		int quiet;
		if (arst_n) begin
			if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end else begin
			quiet = 0;
		end
	end

	initial begin
		arst_n = 1'b0;
		samples_ch.valid = 1'b0;
		samples_ch.cell_value = '0;
		samples_ch.source_term = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_GRID_SIZE;
		cfg_ch.data = '0;
		grid_n = GRID_SIZE_RESET;
		sweep_method = METHOD_JACOBI;
		left_value = '0;
		row_pos = '0;
		col_pos = '0;
		residual_max = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_corner_values();
		test_full_width_rows();
		test_shrink_mid_row();
		test_output_backpressure();
		test_sender_pause();
		test_random_sweeps();
		settle();
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
